>>> rtl/call_descriptor_slot_counter_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef CALL_DESCRIPTOR_SLOT_COUNTER_MACROS_SVH
`define CALL_DESCRIPTOR_SLOT_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("call descriptor slot counter: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("call descriptor slot counter: check failed");

`endif

>>> rtl/cdsc_pkg.sv
package cdsc_pkg;

    localparam int MAX_SLOTS_DEF = 255;

    localparam logic [7:0] CH_OPEN  = 8'h28; // (
    localparam logic [7:0] CH_CLOSE = 8'h29; // )
    localparam logic [7:0] CH_SEMI  = 8'h3B; // ;
    localparam logic [7:0] CH_ARRAY = 8'h5B; // [
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_F     = 8'h46;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_ARGS,
        PH_OBJ,
        PH_ARR,
        PH_RET,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_OPEN,
        ST_BAD_ARG,
        ST_OPEN_OBJ,
        ST_NO_CLOSE,
        ST_BAD_RET
    } t_status;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] ret_slots;
        t_status    err;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{phase: PH_OPEN, ret_slots: 2'd0, err: ST_OK};

    function automatic logic is_one_slot(input logic [7:0] c);
        return (c == CH_B) || (c == CH_S) || (c == CH_I) ||
               (c == CH_C) || (c == CH_Z) || (c == CH_F);
    endfunction

    function automatic logic is_two_slot_ret(input logic [7:0] c);
        return (c == CH_R) || (c == CH_ARRAY) || (c == CH_H) ||
               (c == CH_L) || (c == CH_D);
    endfunction

endpackage

>>> rtl/cdsc_step.sv
module cdsc_step #(
    parameter int MAX_SLOTS = cdsc_pkg::MAX_SLOTS_DEF,
    parameter int SLOT_W    = $clog2(MAX_SLOTS + 1)
) (
    input  cdsc_pkg::t_ctl    i_ctl,
    input  logic [SLOT_W-1:0] i_slots,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    output cdsc_pkg::t_ctl    o_ctl,
    output logic [SLOT_W-1:0] o_slots,
    output logic [7:0]        o_pops,
    output logic [1:0]        o_pushes,
    output logic [2:0]        o_status
);

    localparam logic [SLOT_W:0] SAT = (SLOT_W + 1)'(MAX_SLOTS);

    cdsc_pkg::t_ctl    n_ctl;
    logic [SLOT_W-1:0] n_slots;
    logic              add_one;
    logic              add_two;
    logic [SLOT_W:0]   sum;
    cdsc_pkg::t_status st;

    always_comb begin
        n_ctl   = i_ctl;
        add_one = 1'b0;
        add_two = 1'b0;
        if (i_ctl.err == cdsc_pkg::ST_OK) begin
            unique case (i_ctl.phase)
                cdsc_pkg::PH_OPEN: begin
                    if (i_ch == cdsc_pkg::CH_OPEN) n_ctl.phase = cdsc_pkg::PH_ARGS;
                    else                           n_ctl.err   = cdsc_pkg::ST_NO_OPEN;
                end
                cdsc_pkg::PH_ARGS: begin
                    if (i_ch == cdsc_pkg::CH_CLOSE) begin
                        n_ctl.phase = cdsc_pkg::PH_RET;
                    end else if (cdsc_pkg::is_one_slot(i_ch)) begin
                        add_one = 1'b1;
                    end else if (i_ch == cdsc_pkg::CH_L || i_ch == cdsc_pkg::CH_D) begin
                        add_two = 1'b1;
                    end else if (i_ch == cdsc_pkg::CH_R) begin
                        add_two     = 1'b1;
                        n_ctl.phase = cdsc_pkg::PH_OBJ;
                    end else if (i_ch == cdsc_pkg::CH_ARRAY) begin
                        n_ctl.phase = cdsc_pkg::PH_ARR;
                    end else begin
                        n_ctl.err = cdsc_pkg::ST_BAD_ARG;
                    end
                end
                cdsc_pkg::PH_OBJ: begin
                    if (i_ch == cdsc_pkg::CH_SEMI) n_ctl.phase = cdsc_pkg::PH_ARGS;
                end
                cdsc_pkg::PH_ARR: begin
                    if (i_ch == cdsc_pkg::CH_R) begin
                        add_two     = 1'b1;
                        n_ctl.phase = cdsc_pkg::PH_OBJ;
                    end else if (i_ch != cdsc_pkg::CH_ARRAY) begin
                        add_two     = 1'b1;
                        n_ctl.phase = cdsc_pkg::PH_ARGS;
                    end
                end
                cdsc_pkg::PH_RET: begin
                    if (i_ch == cdsc_pkg::CH_V) begin
                        n_ctl.ret_slots = 2'd0;
                        n_ctl.phase     = cdsc_pkg::PH_DONE;
                    end else if (cdsc_pkg::is_one_slot(i_ch)) begin
                        n_ctl.ret_slots = 2'd1;
                        n_ctl.phase     = cdsc_pkg::PH_DONE;
                    end else if (cdsc_pkg::is_two_slot_ret(i_ch)) begin
                        n_ctl.ret_slots = 2'd2;
                        n_ctl.phase     = cdsc_pkg::PH_DONE;
                    end else begin
                        n_ctl.err = cdsc_pkg::ST_BAD_RET;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        sum = {1'b0, i_slots} + {{SLOT_W{1'b0}}, 1'b0} + (SLOT_W + 1)'({add_two, add_one});
        if (sum > SAT) n_slots = SAT[SLOT_W-1:0];
        else           n_slots = sum[SLOT_W-1:0];
    end

    always_comb begin
        st = n_ctl.err;
        if (st == cdsc_pkg::ST_OK) begin
            unique case (n_ctl.phase)
                cdsc_pkg::PH_ARGS, cdsc_pkg::PH_ARR: st = cdsc_pkg::ST_NO_CLOSE;
                cdsc_pkg::PH_OBJ:                    st = cdsc_pkg::ST_OPEN_OBJ;
                cdsc_pkg::PH_RET:                    st = cdsc_pkg::ST_BAD_RET;
                cdsc_pkg::PH_OPEN:                   st = cdsc_pkg::ST_NO_OPEN;
                default:                             st = cdsc_pkg::ST_OK;
            endcase
        end
        o_status = st;
        if (st == cdsc_pkg::ST_OK) begin
            o_pops   = 8'(n_slots);
            o_pushes = n_ctl.ret_slots;
        end else begin
            o_pops   = 8'd0;
            o_pushes = 2'd0;
        end
        if (i_last) begin
            o_ctl   = cdsc_pkg::CTL_RESET;
            o_slots = '0;
        end else begin
            o_ctl   = n_ctl;
            o_slots = n_slots;
        end
    end

endmodule

>>> rtl/call_descriptor_slot_counter.sv
// Streaming call descriptor parser: feed one ASCII character per transfer on the slave side,
// with tlast on the final character. Characters are taken at one per clock, but a last one
// waits while the prior result is unaccepted; the combinational phase and slot-count update
// between the input register and the state registers sets that rate. Each descriptor yields
// one master-side result, registered after its last character leaves the input register: pops
// (argument slots, saturated at MAX_SLOTS, low 8 bits), pushes (return slots) and status (0 ok,
// 1 no '(', 2 bad argument, 3 unterminated object, 4 no ')', 5 bad return). An error result
// carries zero pops and pushes. The parser returns to its reset state after each descriptor.
module call_descriptor_slot_counter #(
    parameter int MAX_SLOTS = cdsc_pkg::MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] ch
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // [7:0] pops, [9:8] pushes, [12:10] status, [15:13] zero
);

    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);

    logic              r_in_valid;
    logic [7:0]        r_in_ch;
    logic              r_in_last;
    cdsc_pkg::t_ctl    r_ctl;
    logic [SLOT_W-1:0] r_slots;
    logic              r_out_valid;
    logic [15:0]       r_out_data;

    cdsc_pkg::t_ctl    n_ctl;
    logic [SLOT_W-1:0] n_slots;
    logic [7:0]        pops;
    logic [1:0]        pushes;
    logic [2:0]        status;
    logic              out_free;
    logic              in_move;

    cdsc_step #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_step (
        .i_ctl    (r_ctl),
        .i_slots  (r_slots),
        .i_ch     (r_in_ch),
        .i_last   (r_in_last),
        .o_ctl    (n_ctl),
        .o_slots  (n_slots),
        .o_pops   (pops),
        .o_pushes (pushes),
        .o_status (status)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign in_move    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || in_move;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_ctl       <= cdsc_pkg::CTL_RESET;
            r_slots     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) r_in_valid <= i_s_tvalid;
            if (in_move) begin
                r_ctl   <= n_ctl;
                r_slots <= n_slots;
            end
            if (in_move && r_in_last) r_out_valid <= 1'b1;
            else if (i_m_tready)      r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch   <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (in_move && r_in_last) r_out_data <= {3'b000, status, pushes, pops};
    end

endmodule

>>> rtl/cdsc_checker.sv
`include "call_descriptor_slot_counter_macros.svh"

module cdsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // hold a stalled result
    `CDSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // error results carry no slot counts
    `CDSC_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[12:10] != 3'd0), (o_m_tdata[7:0] == 8'd0) && (o_m_tdata[9:8] == 2'd0))
    `CDSC_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_m_tvalid, (o_m_tdata[12:10] <= 3'd5) && (o_m_tdata[15:13] == 3'd0))
    `CDSC_ASSERT_NOW(a_pushes_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[9:8] != 2'd3)

endmodule

bind call_descriptor_slot_counter cdsc_checker u_cdsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import cdsc_pkg::*;

    localparam int SLOT_CAP     = MAX_SLOTS_DEF;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PRESS_CYCLES = 400;
    localparam int PRESS_AFTER  = 150;
    localparam int CHAR_TARGET  = 950;

    localparam logic [7:0] ONE_SLOT_CH [6] = '{CH_B, CH_S, CH_I, CH_C, CH_Z, CH_F};
    localparam logic [7:0] RET_CH [12] = '{CH_V, CH_B, CH_S, CH_I, CH_C, CH_Z, CH_F,
                                           CH_R, CH_ARRAY, CH_H, CH_L, CH_D};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_xfer;

    typedef struct {
        logic [7:0] pops;
        logic [1:0] pushes;
        t_status    status;
    } t_call_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic        i_s_tlast  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;

    call_descriptor_slot_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    t_char_xfer   char_q [$];
    t_call_result results_q [$];
    logic [7:0]   desc_buf [$];

    t_phase     parse_phase = PH_OPEN;
    int         slot_total  = 0;
    logic [1:0] ret_width   = 2'd0;
    t_status    parse_err   = ST_OK;

    int  total_chars   = 0;
    int  in_count      = 0;
    int  results_made  = 0;
    int  results_seen  = 0;
    int  idle_cycles   = 0;
    bit  failed        = 1'b0;
    bit  in_fire       = 1'b0;
    bit  squeeze       = 1'b0;
    bit  send_calm     = 1'b0;
    bit  rcv_calm      = 1'b0;
    bit  press_done    = 1'b0;
    int  press_left    = 0;
    int  hold_left     = 0;
    int  gap_left      = 0;
    t_char_xfer   next_char;
    t_call_result want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit takes_one_slot(input logic [7:0] c);
        return (c == CH_B) || (c == CH_S) || (c == CH_I) ||
               (c == CH_C) || (c == CH_Z) || (c == CH_F);
    endfunction

    task automatic add_slots(input int n);
        slot_total = (slot_total + n > SLOT_CAP) ? SLOT_CAP : slot_total + n;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last_c);
        t_status      st;
        t_call_result res;
        if (parse_err == ST_OK) begin
            case (parse_phase)
                PH_OPEN: begin
                    if (c == CH_OPEN) parse_phase = PH_ARGS;
                    else parse_err = ST_NO_OPEN;
                end
                PH_ARGS: begin
                    if (c == CH_CLOSE) begin
                        parse_phase = PH_RET;
                    end else if (takes_one_slot(c)) begin
                        add_slots(1);
                    end else if (c == CH_L || c == CH_D) begin
                        add_slots(2);
                    end else if (c == CH_R) begin
                        add_slots(2);
                        parse_phase = PH_OBJ;
                    end else if (c == CH_ARRAY) begin
                        parse_phase = PH_ARR;
                    end else begin
                        parse_err = ST_BAD_ARG;
                    end
                end
                PH_OBJ: begin
                    if (c == CH_SEMI) parse_phase = PH_ARGS;
                end
                PH_ARR: begin
                    if (c == CH_R) begin
                        add_slots(2);
                        parse_phase = PH_OBJ;
                    end else if (c != CH_ARRAY) begin
                        add_slots(2);
                        parse_phase = PH_ARGS;
                    end
                end
                PH_RET: begin
                    if (c == CH_V) begin
                        ret_width = 2'd0;
                        parse_phase = PH_DONE;
                    end else if (takes_one_slot(c)) begin
                        ret_width = 2'd1;
                        parse_phase = PH_DONE;
                    end else if (c == CH_R || c == CH_ARRAY || c == CH_H ||
                                 c == CH_L || c == CH_D) begin
                        ret_width = 2'd2;
                        parse_phase = PH_DONE;
                    end else begin
                        parse_err = ST_BAD_RET;
                    end
                end
                default: ;
            endcase
        end
        if (last_c) begin
            st = parse_err;
            if (st == ST_OK) begin
                case (parse_phase)
                    PH_ARGS, PH_ARR: st = ST_NO_CLOSE;
                    PH_OBJ:          st = ST_OPEN_OBJ;
                    PH_RET:          st = ST_BAD_RET;
                    PH_OPEN:         st = ST_NO_OPEN;
                    default:         ;
                endcase
            end
            res.status = st;
            res.pops   = (st == ST_OK) ? slot_total[7:0] : 8'd0;
            res.pushes = (st == ST_OK) ? ret_width : 2'd0;
            results_q.push_back(res);
            results_made++;
            parse_phase = PH_OPEN;
            slot_total  = 0;
            ret_width   = 2'd0;
            parse_err   = ST_OK;
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic last_c);
        char_q.push_back(t_char_xfer'{ch: c, last: last_c});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic add_name();
        logic [7:0] c;
        repeat ($urandom_range(0, 4)) begin
            c = 8'($urandom_range(0, 255));
            desc_buf.push_back((c == CH_SEMI) ? 8'h00 : c);
        end
        desc_buf.push_back(CH_SEMI);
    endtask

    task automatic add_arg();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            desc_buf.push_back(ONE_SLOT_CH[$urandom_range(0, 5)]);
        end else if (r == 4) begin
            desc_buf.push_back(CH_L);
        end else if (r == 5) begin
            desc_buf.push_back(CH_D);
        end else if (r < 8) begin
            desc_buf.push_back(CH_R);
            add_name();
        end else begin
            repeat ($urandom_range(1, 3)) desc_buf.push_back(CH_ARRAY);
            if ($urandom_range(0, 2) == 0) begin
                desc_buf.push_back(CH_R);
                add_name();
            end else begin
                desc_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic build_call();
        desc_buf.delete();
        desc_buf.push_back(CH_OPEN);
        repeat ($urandom_range(0, 6)) add_arg();
        desc_buf.push_back(CH_CLOSE);
        desc_buf.push_back(RET_CH[$urandom_range(0, 11)]);
        repeat ($urandom_range(0, 2)) desc_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic emit_desc();
        for (int i = 0; i < desc_buf.size(); i++) begin
            push_char(desc_buf[i], i == desc_buf.size() - 1);
        end
    endtask

    function automatic int draw_gap();
        int r;
        if (send_calm || squeeze) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                parse_char(i_s_tdata, i_s_tlast);
                in_count++;
            end
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (results_q.size() == 0) begin
                    $display("%0t: result with none expected, actual tdata %h",
                             $time, o_m_tdata);
                    failed = 1'b1;
                end else begin
                    want = results_q.pop_front();
                    if (o_m_tdata[7:0] !== want.pops) begin
                        $display("%0t: pops expected %0d actual %0d",
                                 $time, want.pops, o_m_tdata[7:0]);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[9:8] !== want.pushes) begin
                        $display("%0t: pushes expected %0d actual %0d",
                                 $time, want.pushes, o_m_tdata[9:8]);
                        failed = 1'b1;
                    end
                    if (o_m_tdata[12:10] !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_m_tdata[12:10]);
                        failed = 1'b1;
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || in_fire)) begin
            if (squeeze) gap_left = 0;
            if (gap_left != 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (char_q.size() != 0) begin
                next_char = char_q.pop_front();
                i_s_tdata  <= next_char.ch;
                i_s_tlast  <= next_char.last;
                i_s_tvalid <= 1'b1;
                gap_left = draw_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
            if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!press_done && in_count >= PRESS_AFTER) begin
                press_done = 1'b1;
                press_left = PRESS_CYCLES;
            end
            if (press_left != 0) begin
                press_left--;
                i_m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rcv_calm || $urandom_range(0, 99) < 70) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                hold_left = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 3)
                                                         : $urandom_range(10, 40);
            end
            squeeze <= (press_left != 0);
            if ($urandom_range(0, 99) == 0) rcv_calm = !rcv_calm;
        end
    end

    initial begin
        int n;
        int r;
        int keep;

        push_text("()V");
        push_text("(D[[RA;[I)FZ");
        push_char(8'h00, 1'b1);
        push_text("(B");
        push_char(8'hFF, 1'b0);
        push_text(")I");
        push_text("(Rx");
        push_text("()");
        push_text("()Q");
        push_text("([");

        n = 0;
        while (char_q.size() < CHAR_TARGET) begin
            if (n == 40 || n == 90) begin
                desc_buf.delete();
                desc_buf.push_back(CH_OPEN);
                repeat (135) begin
                    if ($urandom_range(0, 1) != 0) begin
                        desc_buf.push_back(CH_D);
                    end else begin
                        desc_buf.push_back(CH_ARRAY);
                        desc_buf.push_back(CH_B);
                    end
                end
                desc_buf.push_back(CH_CLOSE);
                desc_buf.push_back(CH_V);
            end else begin
                r = $urandom_range(0, 99);
                build_call();
                if (r >= 75 && r < 85) begin
                    keep = $urandom_range(1, desc_buf.size());
                    while (desc_buf.size() > keep) void'(desc_buf.pop_back());
                end else if (r >= 85 && r < 95) begin
                    desc_buf[$urandom_range(0, desc_buf.size() - 1)] =
                        8'($urandom_range(0, 255));
                end else if (r >= 95) begin
                    desc_buf.delete();
                    repeat ($urandom_range(1, 5))
                        desc_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            emit_desc();
            n++;
        end
        total_chars = char_q.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (in_count == total_chars && results_seen == results_made);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (!failed && results_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
